>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, masked while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Types and constants shared by the pressure and temperature compensation
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SENS     = 3'd0,
    REG_OFFSET   = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5
  } reg_index_t;

  localparam int unsigned COEFF_W = 16;
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned TEMP_W  = 19;
  localparam int unsigned PRES_W  = 24;

  // Intermediate widths, sized to the full range of every input.
  localparam int unsigned DT_W    = 25;
  localparam int unsigned PROD_W  = 42;
  localparam int unsigned OFF_W   = 37;
  localparam int unsigned SENS_W  = 36;
  localparam int unsigned SLO_W   = 18;
  localparam int unsigned SHI_W   = SENS_W - SLO_W;
  localparam int unsigned PLO_W   = RAW_W + SLO_W;
  localparam int unsigned PHI_W   = RAW_W + 1 + SHI_W;
  localparam int unsigned PFULL_W = 61;
  localparam int unsigned DIFF_W  = 41;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
  localparam logic signed [PRES_W-1:0] PRES_MAX  = 24'sh7FFFFF;
  localparam logic signed [PRES_W-1:0] PRES_MIN  = 24'sh800000;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_centi;
    logic                     pressure_saturated;
  } result_t;

  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] offset;
    logic [COEFF_W-1:0] tcs;
    logic [COEFF_W-1:0] tco;
    logic [COEFF_W-1:0] tref;
    logic [COEFF_W-1:0] tempsens;
  } coeffs_t;

endpackage

`default_nettype wire

>>> hdl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// First-order compensation of raw barometric pressure and temperature counts.
// ----------------------------------------------------------------------------
// The block turns one raw 24-bit pressure count and one raw 24-bit
// temperature count into a compensated temperature and a compensated,
// saturated pressure, both in hundredths, using six 16-bit calibration
// coefficients. It accepts one sample every cycle while the result side
// does not stall, and the datapath has six register stages: the
// temperature difference, the three coefficient products, the offset and
// sensitivity sums, the split pressure product, the product
// recombination, and the final subtract and clamp in the output register.
// Each stage advances whenever its own slot is empty or the next one
// advances, so bubbles are squeezed out and a stall on the result side
// backs up only as far as it must. Coefficients may change only while the
// pipeline holds no sample.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Sample channel.
  input  wire logic                        sample_valid,
  output logic                             sample_stall,
  input  wire ptc_pkg::sample_t            sample,
  // Result channel.
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output ptc_pkg::result_t                 result,
  // Configuration write channel.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [ptc_pkg::COEFF_W-1:0] cfg_data
);

  // The coefficient registers can take a write in any cycle.
  assign cfg_ready = 1'b1;

  ptc_pkg::coeffs_t coeffs;

  ptc_coef_regs u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeffs    (coeffs)
  );

  // --------------------------------------------------------------------------
  // Stage enables. A stage loads when it is empty or when its content moves
  // on; the output register moves on when the consumer takes the transfer.
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !result_valid || !result_stall;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign sample_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= sample_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
      if (en5) begin
        v5 <= v4;
      end
      if (en6) begin
        result_valid <= v5;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: temperature difference dT = D2 - C5 * 256.
  // --------------------------------------------------------------------------
  logic        [ptc_pkg::RAW_W-1:0] d1_s1;
  logic signed [ptc_pkg::DT_W-1:0]  dt_s1;
  logic signed [ptc_pkg::DT_W-1:0]  dt_next;

  assign dt_next = $signed({1'b0, sample.raw_temperature})
                 - $signed({1'b0, coeffs.tref, 8'h00});

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_s1 <= sample.raw_pressure;
      dt_s1 <= dt_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the three products of dT with C6, C4 and C3.
  // --------------------------------------------------------------------------
  logic        [ptc_pkg::RAW_W-1:0]  d1_s2;
  logic signed [ptc_pkg::PROD_W-1:0] prod_temp_s2;
  logic signed [ptc_pkg::PROD_W-1:0] prod_off_s2;
  logic signed [ptc_pkg::PROD_W-1:0] prod_sens_s2;

  always_ff @(posedge clk) begin
    if (en2) begin
      d1_s2        <= d1_s1;
      prod_temp_s2 <= ptc_pkg::PROD_W'(dt_s1 * $signed({1'b0, coeffs.tempsens}));
      prod_off_s2  <= ptc_pkg::PROD_W'(dt_s1 * $signed({1'b0, coeffs.tco}));
      prod_sens_s2 <= ptc_pkg::PROD_W'(dt_s1 * $signed({1'b0, coeffs.tcs}));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: TEMP, OFF and SENS. The arithmetic shifts are floor divisions.
  // --------------------------------------------------------------------------
  logic        [ptc_pkg::RAW_W-1:0]  d1_s3;
  logic signed [ptc_pkg::TEMP_W-1:0] temp_s3;
  logic signed [ptc_pkg::OFF_W-1:0]  off_s3;
  logic signed [ptc_pkg::SENS_W-1:0] sens_s3;

  logic signed [ptc_pkg::PROD_W-1:0] temp_shift;
  logic signed [ptc_pkg::PROD_W-1:0] off_shift;
  logic signed [ptc_pkg::PROD_W-1:0] sens_shift;
  logic signed [ptc_pkg::TEMP_W-1:0] temp_next;
  logic signed [ptc_pkg::OFF_W-1:0]  off_next;
  logic signed [ptc_pkg::SENS_W-1:0] sens_next;

  always_comb begin
    temp_shift = prod_temp_s2 >>> 23;
    off_shift  = prod_off_s2 >>> 6;
    sens_shift = prod_sens_s2 >>> 7;
    temp_next  = temp_shift[ptc_pkg::TEMP_W-1:0] + ptc_pkg::TEMP_BASE;
    off_next   = off_shift[ptc_pkg::OFF_W-1:0]
               + $signed({4'b0, coeffs.offset, 17'b0});
    sens_next  = sens_shift[ptc_pkg::SENS_W-1:0]
               + $signed({4'b0, coeffs.sens, 16'b0});
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      d1_s3   <= d1_s2;
      temp_s3 <= temp_next;
      off_s3  <= off_next;
      sens_s3 <= sens_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: D1 * SENS as two partial products, SENS split into an unsigned
  // low part and a signed high part.
  // --------------------------------------------------------------------------
  logic signed [ptc_pkg::TEMP_W-1:0] temp_s4;
  logic signed [ptc_pkg::OFF_W-1:0]  off_s4;
  logic        [ptc_pkg::PLO_W-1:0]  plo_s4;
  logic signed [ptc_pkg::PHI_W-1:0]  phi_s4;

  logic        [ptc_pkg::SLO_W-1:0]  sens_lo;
  logic signed [ptc_pkg::SHI_W-1:0]  sens_hi;

  assign sens_lo = sens_s3[ptc_pkg::SLO_W-1:0];
  assign sens_hi = $signed(sens_s3[ptc_pkg::SENS_W-1:ptc_pkg::SLO_W]);

  always_ff @(posedge clk) begin
    if (en4) begin
      temp_s4 <= temp_s3;
      off_s4  <= off_s3;
      plo_s4  <= ptc_pkg::PLO_W'(d1_s3 * sens_lo);
      phi_s4  <= ptc_pkg::PHI_W'($signed({1'b0, d1_s3}) * sens_hi);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: recombine the partial products into the full D1 * SENS.
  // --------------------------------------------------------------------------
  logic signed [ptc_pkg::TEMP_W-1:0]  temp_s5;
  logic signed [ptc_pkg::OFF_W-1:0]   off_s5;
  logic signed [ptc_pkg::PFULL_W-1:0] pfull_s5;
  logic signed [ptc_pkg::PFULL_W-1:0] pfull_next;

  assign pfull_next = $signed({phi_s4, {ptc_pkg::SLO_W{1'b0}}})
                    + $signed({{(ptc_pkg::PFULL_W - ptc_pkg::PLO_W){1'b0}}, plo_s4});

  always_ff @(posedge clk) begin
    if (en5) begin
      temp_s5  <= temp_s4;
      off_s5   <= off_s4;
      pfull_s5 <= pfull_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6 (output register): P = floor((floor(D1*SENS/2^21) - OFF)/2^15),
  // clamped to the signed 24-bit range.
  // --------------------------------------------------------------------------
  logic signed [ptc_pkg::PFULL_W-1:0] pfull_shift;
  logic signed [ptc_pkg::DIFF_W-1:0]  diff;
  logic signed [ptc_pkg::DIFF_W-1:0]  p_wide;
  ptc_pkg::result_t                   result_next;

  always_comb begin
    pfull_shift = pfull_s5 >>> 21;
    diff        = pfull_shift[ptc_pkg::DIFF_W-1:0]
                - ptc_pkg::DIFF_W'(off_s5);
    p_wide      = diff >>> 15;

    result_next.temperature_centi = temp_s5;
    if (p_wide > ptc_pkg::DIFF_W'(ptc_pkg::PRES_MAX)) begin
      result_next.pressure_centi     = ptc_pkg::PRES_MAX;
      result_next.pressure_saturated = 1'b1;
    end else if (p_wide < ptc_pkg::DIFF_W'(ptc_pkg::PRES_MIN)) begin
      result_next.pressure_centi     = ptc_pkg::PRES_MIN;
      result_next.pressure_saturated = 1'b1;
    end else begin
      result_next.pressure_centi     = p_wide[ptc_pkg::PRES_W-1:0];
      result_next.pressure_saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ptc_coef_regs.sv
// ----------------------------------------------------------------------------
// ptc_coef_regs
// Holds the six factory calibration coefficients written over the
// configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_coef_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [2:0]                      cfg_index,
  input  wire logic [ptc_pkg::COEFF_W-1:0]     cfg_data,
  output ptc_pkg::coeffs_t                     coeffs
);

  ptc_pkg::coeffs_t regs;

  // Writes to an index outside the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid) begin
      case (ptc_pkg::reg_index_t'(cfg_index))
        ptc_pkg::REG_SENS:     regs.sens     <= cfg_data;
        ptc_pkg::REG_OFFSET:   regs.offset   <= cfg_data;
        ptc_pkg::REG_TCS:      regs.tcs      <= cfg_data;
        ptc_pkg::REG_TCO:      regs.tco      <= cfg_data;
        ptc_pkg::REG_TREF:     regs.tref     <= cfg_data;
        ptc_pkg::REG_TEMPSENS: regs.tempsens <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign coeffs = regs;

endmodule

`default_nettype wire

>>> hdl/ptc_checker.sv
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks for the compensation block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        sample_valid,
  input wire logic                        sample_stall,
  input wire ptc_pkg::sample_t            sample,
  input wire logic                        result_valid,
  input wire logic                        result_stall,
  input wire ptc_pkg::result_t            result,
  input wire logic                        cfg_valid,
  input wire logic                        cfg_ready,
  input wire logic [2:0]                  cfg_index,
  input wire logic [ptc_pkg::COEFF_W-1:0] cfg_data
);

  logic unused_ok;

  assign unused_ok = sample_valid ^ (^sample) ^ cfg_valid ^ cfg_ready
                   ^ (^cfg_index) ^ (^cfg_data);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid, "stalled result dropped")

  // With no result waiting, the pipeline has room for a new sample.
  `ASSERT_IMPLY(a_no_stall_empty, clk, rst, !result_valid, !sample_stall, "sample stalled with empty output")

  // A clamped pressure sits on one of the two bounds.
  `ASSERT_IMPLY(a_sat_bound, clk, rst, result_valid && result.pressure_saturated, (result.pressure_centi == ptc_pkg::PRES_MAX) || (result.pressure_centi == ptc_pkg::PRES_MIN), "saturated pressure off bound")

  // The compensated temperature stays in its reachable range.
  `ASSERT_IMPLY(a_temp_range, clk, rst, result_valid, (result.temperature_centi >= -19'sd129070) && (result.temperature_centi <= 19'sd133072), "temperature out of range")

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data)
);

`default_nettype wire

>>> dv/tb_pressure_temperature_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pressure_temperature_compensation
// Self-checking bench for the barometric first-order compensation block.
// ----------------------------------------------------------------------------
// Raw pressure and temperature pairs are pushed through the sample channel in
// bursts with random gaps. The result channel stalls according to a pattern
// of its own. A scoreboard class holds a bit-exact predictor of the
// compensation arithmetic and its own copy of the six coefficients. Every
// accepted reading is compared field by field, in order, with the
// prediction. The run starts with directed corner pairs under hand-picked
// coefficient sets and then moves on to random pairs under random sets.
// ----------------------------------------------------------------------------

module tb_pressure_temperature_compensation;

  localparam int unsigned CLK_HALF         = 4;
  localparam int unsigned RESET_CYCLES     = 7;
  // The datapath has six register stages. The drain wait after the last
  // reading leaves a wide margin before coefficients are rewritten.
  localparam int unsigned DRAIN_CYCLES     = 12;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned RANDOM_PER_PHASE = 190;
  localparam int unsigned REPORT_BUDGET    = 10;

  // The index field is three bits wide, but only six registers exist. These
  // two indexes must be ignored by the block.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam logic [ptc_pkg::RAW_W-1:0]   RAW_MAX   = '1;
  localparam logic [ptc_pkg::COEFF_W-1:0] COEFF_MAX = '1;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_TOGGLE, STALL_HEAVY} stall_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each reading when a sample transfer happens and
  // checks the readings in arrival order.
  // --------------------------------------------------------------------------
  class compensation_scoreboard;
    ptc_pkg::coeffs_t coeffs;
    ptc_pkg::result_t pending[$];
    int unsigned      noted;
    int unsigned      checked;
    int unsigned      mismatches;

    function new();
      coeffs     = '0;
      noted      = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    // Writes to indexes beyond the register list leave the copy untouched.
    function void set_coeff(logic [2:0] index, logic [ptc_pkg::COEFF_W-1:0] value);
      case (index)
        ptc_pkg::REG_SENS:     coeffs.sens     = value;
        ptc_pkg::REG_OFFSET:   coeffs.offset   = value;
        ptc_pkg::REG_TCS:      coeffs.tcs      = value;
        ptc_pkg::REG_TCO:      coeffs.tco      = value;
        ptc_pkg::REG_TREF:     coeffs.tref     = value;
        ptc_pkg::REG_TEMPSENS: coeffs.tempsens = value;
        default: ;
      endcase
    endfunction

    // Exact integer compensation. All operands are signed 64-bit values, so
    // every >>> is an arithmetic shift, which is a floor division by a power
    // of two. No intermediate value comes near 2^63.
    function ptc_pkg::result_t compensate(ptc_pkg::sample_t s);
      longint           d1, d2, c1, c2, c3, c4, c5, c6;
      longint           dt, temp, off, sens, p;
      ptc_pkg::result_t r;
      d1 = longint'(s.raw_pressure);
      d2 = longint'(s.raw_temperature);
      c1 = longint'(coeffs.sens);
      c2 = longint'(coeffs.offset);
      c3 = longint'(coeffs.tcs);
      c4 = longint'(coeffs.tco);
      c5 = longint'(coeffs.tref);
      c6 = longint'(coeffs.tempsens);
      dt   = d2 - (c5 <<< 8);
      temp = longint'(ptc_pkg::TEMP_BASE) + ((dt * c6) >>> 23);
      off  = (c2 <<< 17) + ((dt * c4) >>> 6);
      sens = (c1 <<< 16) + ((dt * c3) >>> 7);
      p    = (((d1 * sens) >>> 21) - off) >>> 15;
      r.pressure_saturated = 1'b0;
      if (p > longint'(ptc_pkg::PRES_MAX)) begin
        p = longint'(ptc_pkg::PRES_MAX);
        r.pressure_saturated = 1'b1;
      end else if (p < longint'(ptc_pkg::PRES_MIN)) begin
        p = longint'(ptc_pkg::PRES_MIN);
        r.pressure_saturated = 1'b1;
      end
      r.temperature_centi = temp[ptc_pkg::TEMP_W-1:0];
      r.pressure_centi    = p[ptc_pkg::PRES_W-1:0];
      return r;
    endfunction

    function void note_sample(ptc_pkg::sample_t s);
      pending.push_back(compensate(s));
      noted++;
    endfunction

    function void check_reading(ptc_pkg::result_t got);
      ptc_pkg::result_t want;
      if (pending.size() == 0) begin
        if (mismatches < REPORT_BUDGET)
          $display("Unexpected reading: temp %0d pres %0d sat %0b",
                   got.temperature_centi, got.pressure_centi, got.pressure_saturated);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.temperature_centi !== want.temperature_centi ||
          got.pressure_centi !== want.pressure_centi ||
          got.pressure_saturated !== want.pressure_saturated) begin
        if (mismatches < REPORT_BUDGET)
          $display("Reading %0d differs: expected temp %0d pres %0d sat %0b,",
                   checked, want.temperature_centi, want.pressure_centi,
                   want.pressure_saturated, " got temp %0d pres %0d sat %0b",
                   got.temperature_centi, got.pressure_centi,
                   got.pressure_saturated);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block under test. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  ptc_pkg::sample_t              sample       = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  ptc_pkg::result_t              result;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [2:0]                    cfg_index    = '0;
  logic [ptc_pkg::COEFF_W-1:0]   cfg_data     = '0;

  compensation_scoreboard sb;
  int unsigned            cycle_count = 0;
  int unsigned            coeff_sets  = 0;

  pressure_temperature_compensation u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case a transfer never completes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit of %0d cycles.", CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side. Values read right after the edge are the ones the edge saw,
  // because the block's registers only update in the nonblocking region.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_reading(result);
  end

  // The receiver runs through stretches of differing stall behavior: none at
  // all, sparse random stalls, strict alternation, and long heavy backups.
  // Stretch lengths do not line up with the sender's bursts, so stalls land
  // on every phase of the pipeline.
  initial begin
    stall_mode_t mode;
    int unsigned span;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:   result_stall <= 1'b0;
          STALL_RANDOM: result_stall <= ($urandom_range(0, 99) < 30);
          STALL_TOGGLE: result_stall <= ~result_stall;
          default:      result_stall <= ($urandom_range(0, 99) < 80);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------

  // Raises valid with the payload and holds both until the transfer. Valid
  // stays high on return so a following sample goes out back to back.
  task automatic send_sample(input ptc_pkg::sample_t s);
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(s);
  endtask

  task automatic send_pair(input logic [ptc_pkg::RAW_W-1:0] d1,
                           input logic [ptc_pkg::RAW_W-1:0] d2);
    ptc_pkg::sample_t s;
    s.raw_pressure    = d1;
    s.raw_temperature = d2;
    send_sample(s);
  endtask

  task automatic hold_off(input int unsigned cycles);
    sample_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until every predicted reading has arrived, then lets the pipeline
  // settle before any coefficient is touched.
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] index,
                                input logic [ptc_pkg::COEFF_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_coeff(index, value);
  endtask

  // Writes all six coefficients back to back, with writes to the two unused
  // indexes before and after them. Those must not disturb any coefficient.
  task automatic load_coefficients(input ptc_pkg::coeffs_t c);
    write_register(REG_SPARE_HI, ptc_pkg::COEFF_W'($urandom));
    write_register(ptc_pkg::REG_SENS, c.sens);
    write_register(ptc_pkg::REG_OFFSET, c.offset);
    write_register(ptc_pkg::REG_TCS, c.tcs);
    write_register(ptc_pkg::REG_TCO, c.tco);
    write_register(ptc_pkg::REG_TREF, c.tref);
    write_register(ptc_pkg::REG_TEMPSENS, c.tempsens);
    write_register(REG_SPARE_LO, ptc_pkg::COEFF_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    coeff_sets++;
  endtask

  // Some sets lean toward the ends of the coefficient range.
  function automatic logic [ptc_pkg::COEFF_W-1:0] random_coeff(input bit lean_to_ends);
    if (lean_to_ends) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return COEFF_MAX;
        default: return ptc_pkg::COEFF_W'($urandom);
      endcase
    end
    return ptc_pkg::COEFF_W'($urandom);
  endfunction

  // Random pairs in bursts of random length separated by random gaps. About
  // one burst in four follows the previous one with no gap at all.
  task automatic run_random_phase(input int unsigned count);
    ptc_pkg::sample_t s;
    int unsigned      sent;
    int unsigned      burst;
    int unsigned      pick;
    int               near;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && sent < count) begin
        pick = $urandom_range(0, 99);
        s.raw_pressure    = ptc_pkg::RAW_W'($urandom);
        s.raw_temperature = ptc_pkg::RAW_W'($urandom);
        if (pick < 15) begin
          // Field extremes, mixed with random values.
          case ($urandom_range(0, 2))
            0:       s.raw_pressure = '0;
            1:       s.raw_pressure = RAW_MAX;
            default: ;
          endcase
          case ($urandom_range(0, 2))
            0:       s.raw_temperature = '0;
            1:       s.raw_temperature = RAW_MAX;
            default: ;
          endcase
        end else if (pick < 30) begin
          // Temperature count close to the reference, so the difference is
          // small and changes sign, which exercises the floor of each shift.
          near = int'({sb.coeffs.tref, 8'h00}) + int'($urandom_range(0, 64)) - 32;
          if (near < 0)
            near = 0;
          if (near > int'(RAW_MAX))
            near = int'(RAW_MAX);
          s.raw_temperature = near[ptc_pkg::RAW_W-1:0];
        end else if (pick < 40) begin
          // Counts of the size a real sensor produces.
          s.raw_pressure    = ptc_pkg::RAW_W'($urandom_range(6000000, 10000000));
          s.raw_temperature = ptc_pkg::RAW_W'($urandom_range(7000000, 9000000));
        end
        send_sample(s);
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0)
        hold_off($urandom_range(1, 6));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    ptc_pkg::coeffs_t c;
    bit               lean;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Coefficients still at their reset value of zero.
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair('0, RAW_MAX);
    send_pair(RAW_MAX, '0);
    send_pair(24'h800000, 24'h7FFFFF);
    wait_idle();

    // Every coefficient at full scale. A zero temperature count gives the
    // most negative temperature difference and the lowest temperature.
    c = '1;
    load_coefficients(c);
    send_pair('0, '0);
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    send_pair(RAW_MAX, RAW_MAX);
    wait_idle();

    // Zero reference and full temperature gain: the highest temperature and,
    // with full sensitivity and no offset, the largest pressure.
    c = '{sens: COEFF_MAX, offset: '0, tcs: COEFF_MAX, tco: '0, tref: '0,
          tempsens: COEFF_MAX};
    load_coefficients(c);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    send_pair(24'h555555, 24'hAAAAAA);
    wait_idle();

    // Negative sensitivity against a large offset: the most negative
    // pressure.
    c = '{sens: '0, offset: COEFF_MAX, tcs: COEFF_MAX, tco: '0, tref: COEFF_MAX,
          tempsens: '0};
    load_coefficients(c);
    send_pair(RAW_MAX, '0);
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    wait_idle();

    // Typical factory values. The reference here is 8077568, so the middle
    // pairs give a temperature difference of zero and of minus one.
    c = '{sens: 16'd46372, offset: 16'd43981, tcs: 16'd29059, tco: 16'd27842,
          tref: 16'd31553, tempsens: 16'd28165};
    load_coefficients(c);
    send_pair(24'd6465444, 24'd8077636);
    send_pair(24'd6465444, 24'd8077568);
    send_pair(24'd6465444, 24'd8077567);
    send_pair(RAW_MAX, 24'd8077569);
    wait_idle();

    // Random phases, every third one with coefficients pushed to the ends.
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      lean = (ph % 3 == 0);
      c.sens     = random_coeff(lean);
      c.offset   = random_coeff(lean);
      c.tcs      = random_coeff(lean);
      c.tco      = random_coeff(lean);
      c.tref     = random_coeff(lean);
      c.tempsens = random_coeff(lean);
      load_coefficients(c);
      run_random_phase(RANDOM_PER_PHASE);
      wait_idle();
    end

    $display("Compensated %0d sample pairs under %0d coefficient sets plus reset values.",
             sb.noted, coeff_sets);
    $display("Checked %0d readings against the predictor; %0d mismatches.",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
